FILE: src/sfr_pkg.sv
// Package for the serial frame receiver: item and result types, parser state
// encoding and frame constants. No dependencies.
package sfr_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
  localparam int          PAYLOAD_LEN    = 9;
  localparam int          IDX_W          = $clog2(PAYLOAD_LEN + 1);
  localparam logic [15:0] AGE_MAX        = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd500;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic {
    ST_HUNT    = 1'b0,
    ST_COLLECT = 1'b1
  } sfr_state_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } sfr_item_t;

  typedef struct packed {
    logic [31:0] angle_bits;
    logic [31:0] distance_bits;
    logic        target_seen;
    logic        stale;
    logic        frame_accepted;
    logic        frame_rejected;
  } sfr_result_t;

endpackage

FILE: src/sfr_if.sv
// Valid/ready channel interfaces for the serial frame receiver.
// Input channel carries one byte or tick; output channel carries one result.
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] angle_bits;
  logic [31:0] distance_bits;
  logic        target_seen;
  logic        stale;
  logic        frame_accepted;
  logic        frame_rejected;

  modport source (output valid, output angle_bits, output distance_bits,
                  output target_seen, output stale, output frame_accepted,
                  output frame_rejected, input ready);
  modport sink   (input valid, input angle_bits, input distance_bits,
                  input target_seen, input stale, input frame_accepted,
                  input frame_rejected, output ready);
endinterface

FILE: src/sfr_in_stage.sv
// Input register of the serial frame receiver.
// Depends on sfr_pkg for the item type.
module sfr_in_stage import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfr_item_t in_item,
  input  logic      step,
  output logic      s1_valid,
  output sfr_item_t s1_item
);

  logic      valid_r, valid_nxt;
  sfr_item_t item_r;
  logic      take;

  // Accept when empty or when the held transaction moves on this cycle
  assign in_ready = !valid_r || step;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register, no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

FILE: src/sfr_parser.sv
// Frame parser of the serial frame receiver: start-byte hunt, payload and
// XOR collection, latched values, tick age and timeout. Depends on sfr_pkg.
module sfr_parser import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        step,
  input  sfr_item_t   item,
  output sfr_result_t result
);

  sfr_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       payload_r [PAYLOAD_LEN];
  logic [31:0]      angle_r, angle_nxt;
  logic [31:0]      dist_r, dist_nxt;
  logic             seen_r, seen_nxt;
  logic [15:0]      age_r, age_nxt;
  logic [15:0]      timeout_r;
  logic             is_byte;
  logic             store_en;
  logic             csum_byte;
  logic             good;

  assign is_byte   = (item.kind == KIND_BYTE);
  assign csum_byte = is_byte && (state_r == ST_COLLECT)
                     && (idx_r >= IDX_W'(PAYLOAD_LEN));
  assign store_en  = is_byte && (state_r == ST_COLLECT)
                     && (idx_r < IDX_W'(PAYLOAD_LEN));
  assign good      = csum_byte && (xor_r == item.rx_byte);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (is_byte && item.rx_byte == SYNC_BYTE) begin
          state_nxt = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (csum_byte) begin
          state_nxt = ST_HUNT;
        end
      end
      default: state_nxt = ST_HUNT;
    endcase
  end

  // Datapath and result
  always_comb begin
    idx_nxt   = idx_r;
    xor_nxt   = xor_r;
    angle_nxt = angle_r;
    dist_nxt  = dist_r;
    seen_nxt  = seen_r;
    age_nxt   = age_r;
    if (!is_byte) begin
      if (age_r != AGE_MAX) begin
        age_nxt = age_r + 16'd1;
      end
    end else if (state_r == ST_HUNT) begin
      idx_nxt = '0;
      xor_nxt = '0;
    end else if (store_en) begin
      xor_nxt = xor_r ^ item.rx_byte;
      idx_nxt = idx_r + IDX_W'(1);
    end else begin
      if (good) begin
        angle_nxt = {payload_r[3], payload_r[2], payload_r[1], payload_r[0]};
        dist_nxt  = {payload_r[7], payload_r[6], payload_r[5], payload_r[4]};
        seen_nxt  = (payload_r[8] != 8'd0);
        age_nxt   = '0;
      end
      idx_nxt = '0;
      xor_nxt = '0;
    end

    result.angle_bits     = angle_nxt;
    result.distance_bits  = dist_nxt;
    result.target_seen    = seen_nxt;
    result.stale          = (age_nxt > timeout_r);
    result.frame_accepted = good;
    result.frame_rejected = csum_byte && !good;
  end

  // Control and latched values advance with each transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      idx_r   <= '0;
      xor_r   <= '0;
      angle_r <= '0;
      dist_r  <= '0;
      seen_r  <= 1'b0;
      age_r   <= AGE_MAX;
    end else if (step) begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      xor_r   <= xor_nxt;
      angle_r <= angle_nxt;
      dist_r  <= dist_nxt;
      seen_r  <= seen_nxt;
      age_r   <= age_nxt;
    end
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  // Payload bytes, no reset
  always_ff @(posedge clk) begin
    if (step && store_en) begin
      payload_r[idx_r] <= item.rx_byte;
    end
  end

endmodule

FILE: src/sfr_out_stage.sv
// Result register of the serial frame receiver.
// Depends on sfr_pkg for the result type.
module sfr_out_stage import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s1_valid,
  input  sfr_result_t result,
  input  logic        out_ready,
  output logic        out_valid,
  output sfr_result_t out_result,
  output logic        step
);

  logic        valid_r, valid_nxt;
  sfr_result_t result_r;

  // Move the held item on when the result slot is free or being drained
  assign step = s1_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: src/serial_frame_receiver_with_timeout.sv
// Top level of the serial frame receiver with timeout.
// Depends on sfr_pkg, sfr_if, sfr_in_stage, sfr_parser and sfr_out_stage.
//
// Usage:
//   in_if  : valid/ready channel of items; kind 0 is a received serial byte
//            (rx_byte), kind 1 is one millisecond tick.
//   out_if : valid/ready channel with exactly one result per item: latest
//            angle and distance bits, target flag, stale flag and the
//            frame accepted/rejected strobes for the byte just processed.
//   cfg_we / cfg_wdata : write of the 16-bit timeout in ticks; write only
//            while no transaction is in flight.
// Path: an accepted item is held in the input register, and its parser result
//   is captured in the result register, which drives out_if.valid.
// Throughput: one item per cycle while out_if.ready does not hold results back;
//   the parser updates its state as an item moves to the result register.
// Reset: parser hunts for the start byte, latched values are zero, the
//   age counter is saturated so results read stale, timeout is 500.
// Stall: a result not taken is held; the input register takes one more
//   transaction, after which in_if.ready stays low until out_if.ready.
module serial_frame_receiver_with_timeout import sfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  sfr_in_if.sink      in_if,
  sfr_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  sfr_item_t   in_item;
  sfr_item_t   s1_item;
  logic        s1_valid;
  logic        step;
  sfr_result_t result;
  sfr_result_t out_result;

  assign in_item.kind    = in_if.kind;
  assign in_item.rx_byte = in_if.rx_byte;

  sfr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_item  (in_item),
    .step     (step),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  sfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (s1_item),
    .result    (result)
  );

  sfr_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (result),
    .out_ready  (out_if.ready),
    .out_valid  (out_if.valid),
    .out_result (out_result),
    .step       (step)
  );

  assign out_if.angle_bits     = out_result.angle_bits;
  assign out_if.distance_bits  = out_result.distance_bits;
  assign out_if.target_seen    = out_result.target_seen;
  assign out_if.stale          = out_result.stale;
  assign out_if.frame_accepted = out_result.frame_accepted;
  assign out_if.frame_rejected = out_result.frame_rejected;

  // A frame ends either good or bad, never both
  a_accept_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> !(out_if.frame_accepted && out_if.frame_rejected))
    else $error("frame both accepted and rejected");

  // A good frame clears the age, so it cannot report stale
  a_accept_not_stale: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.frame_accepted |-> !out_if.stale)
    else $error("accepted frame reported stale");

  // Input backpressure only when both stages are full and output stalls
  a_ready_low_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> s1_valid && out_if.valid && !out_if.ready)
    else $error("input stalled without a full pipeline");

endmodule

FILE: test/tb_serial_frame_receiver_with_timeout.sv
// Testbench for serial_frame_receiver_with_timeout: drives bytes and ticks,
// predicts each readout and compares it field by field with the block's output.
// Depends on sfr_pkg, sfr_if and the RTL of the receiver.
`timescale 1ns / 100ps

module tb_serial_frame_receiver_with_timeout;
  import sfr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  serial_frame_receiver_with_timeout dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Own copy of the parser, latched values and timeout
  sfr_state_t  parse_state;
  logic [3:0]  frame_pos;
  logic [7:0]  frame_xor;
  logic [7:0]  frame_bytes [0:PAYLOAD_LEN-1];
  logic [31:0] latched_angle;
  logic [31:0] latched_distance;
  logic        latched_seen;
  logic [15:0] age_count;
  logic [15:0] timeout_ticks;

  sfr_result_t pending_readouts [$];
  int          err_count;
  int          items_sent;
  bit          idle_on;
  int          stall_left;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, a few long ones; none while idling is off
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  // Bias byte values toward zero, all ones and the start byte
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return SYNC_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Advance the parser by one item and return the readout it produces
  function automatic sfr_result_t readout_after(input logic k, input logic [7:0] b);
    sfr_result_t r;
    r = '0;
    if (k == KIND_TICK) begin
      if (age_count != AGE_MAX) age_count = age_count + 16'd1;
    end else if (parse_state == ST_HUNT) begin
      if (b == SYNC_BYTE) begin
        parse_state = ST_COLLECT;
        frame_pos = '0;
        frame_xor = '0;
      end
    end else if (frame_pos < PAYLOAD_LEN) begin
      frame_bytes[frame_pos] = b;
      frame_xor = frame_xor ^ b;
      frame_pos = frame_pos + 4'd1;
    end else begin
      if (frame_xor == b) begin
        latched_angle    = {frame_bytes[3], frame_bytes[2], frame_bytes[1], frame_bytes[0]};
        latched_distance = {frame_bytes[7], frame_bytes[6], frame_bytes[5], frame_bytes[4]};
        latched_seen     = (frame_bytes[8] != 8'h00);
        age_count        = '0;
        r.frame_accepted = 1'b1;
      end else begin
        r.frame_rejected = 1'b1;
      end
      parse_state = ST_HUNT;
      frame_pos = '0;
      frame_xor = '0;
    end
    r.angle_bits    = latched_angle;
    r.distance_bits = latched_distance;
    r.target_seen   = latched_seen;
    r.stale         = (age_count > timeout_ticks);
    return r;
  endfunction

  // Offer one item after a random gap and hold it until the transaction
  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= k;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_readouts.push_back(readout_after(k, b));
    items_sent++;
  endtask

  // Drop valid and wait until every expected readout has arrived
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_readouts.size() != 0);
  endtask

  task automatic write_timeout(input logic [15:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_ticks = value;
  endtask

  // Start byte, nine payload bytes, XOR checksum; ticks may be mixed in
  task automatic send_frame(input logic [8*PAYLOAD_LEN-1:0] payload, input bit corrupt,
                            input bit tick_mix);
    logic [7:0] sum;
    int i;
    sum = 8'h00;
    send_item(KIND_BYTE, SYNC_BYTE);
    for (i = 0; i < PAYLOAD_LEN; i++) begin
      if (tick_mix && $urandom_range(0, 9) == 0)
        send_item(KIND_TICK, 8'($urandom_range(0, 255)));
      send_item(KIND_BYTE, payload[8*i +: 8]);
      sum = sum ^ payload[8*i +: 8];
    end
    if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
    send_item(KIND_BYTE, sum);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t: mismatch on %s, expected %h, actual %h", $time, field, want, got);
    err_count++;
  endtask

  // Check each output transaction and drive ready with random stalls
  always @(posedge clk) begin : result_monitor
    sfr_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_readouts.size() == 0) begin
        $display("%0t: readout with none expected, actual angle %h distance %h", $time,
                 out_ch.angle_bits, out_ch.distance_bits);
        err_count++;
      end else begin
        want = pending_readouts.pop_front();
        if (out_ch.angle_bits !== want.angle_bits)
          report_mismatch("angle_bits", want.angle_bits, out_ch.angle_bits);
        if (out_ch.distance_bits !== want.distance_bits)
          report_mismatch("distance_bits", want.distance_bits, out_ch.distance_bits);
        if (out_ch.target_seen !== want.target_seen)
          report_mismatch("target_seen", 32'(want.target_seen), 32'(out_ch.target_seen));
        if (out_ch.stale !== want.stale)
          report_mismatch("stale", 32'(want.stale), 32'(out_ch.stale));
        if (out_ch.frame_accepted !== want.frame_accepted)
          report_mismatch("frame_accepted", 32'(want.frame_accepted),
                          32'(out_ch.frame_accepted));
        if (out_ch.frame_rejected !== want.frame_rejected)
          report_mismatch("frame_rejected", 32'(want.frame_rejected),
                          32'(out_ch.frame_rejected));
      end
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // Stale right after reset, tick with a don't-care byte, noise dropped while hunting
  task automatic test_reset_and_hunt();
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_BYTE, 8'h00);
  endtask

  // Largest timeout: a saturated age never counts as stale
  task automatic test_timeout_max();
    write_timeout(16'hFFFF);
    send_item(KIND_TICK, 8'h5A);
  endtask

  // Good frame with start bytes and extremes in the payload, then a tick at timeout zero
  task automatic test_frame_accept();
    write_timeout(16'h0000);
    send_frame({8'h01, 8'h55, 8'hAA, 8'h7F, 8'h01, 8'h80, 8'hAA, 8'hFF, 8'h00}, 1'b0, 1'b0);
    send_item(KIND_TICK, 8'h00);
  endtask

  // Bad checksum leaves the latched values alone
  task automatic test_frame_reject();
    send_frame({8'h00, 8'hFF, 8'h12, 8'hAA, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC}, 1'b1, 1'b0);
    drain_results();
  endtask

  // Phases of random frames, noise and ticks under several timeouts
  task automatic test_random_phases();
    int p;
    int start_count;
    int n;
    int i;
    bit paused;
    logic [8*PAYLOAD_LEN-1:0] payload;
    logic [15:0] phase_timeouts [0:5];
    phase_timeouts[0] = 16'd1;
    phase_timeouts[1] = 16'd4;
    phase_timeouts[2] = 16'd25;
    phase_timeouts[3] = 16'hFFFF;
    phase_timeouts[4] = 16'd0;
    phase_timeouts[5] = 16'($urandom_range(0, 65535));
    for (p = 0; p < 6; p++) begin
      write_timeout(phase_timeouts[p]);
      start_count = items_sent;
      paused = 1'b0;
      while (items_sent - start_count < 267) begin
        idle_on = ($urandom_range(0, 4) != 0);
        // Hold off once per phase until the output side catches up
        if (!paused && items_sent - start_count > 130) begin
          drain_results();
          paused = 1'b1;
        end
        case ($urandom_range(0, 19))
          0, 1, 2: begin
            n = $urandom_range(1, 4);
            for (i = 0; i < n; i++) send_item(KIND_BYTE, pick_byte());
          end
          3, 4, 5: begin
            n = $urandom_range(1, 6);
            for (i = 0; i < n; i++) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
          end
          default: begin
            for (i = 0; i < PAYLOAD_LEN; i++) payload[8*i +: 8] = pick_byte();
            if ($urandom_range(0, 3) == 0) payload[8*(PAYLOAD_LEN-1) +: 8] = 8'h00;
            send_frame(payload, $urandom_range(0, 3) == 0, 1'b1);
            n = (timeout_ticks <= 16'd64) ? $urandom_range(0, timeout_ticks + 2)
                                          : $urandom_range(0, 4);
            for (i = 0; i < n; i++) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
          end
        endcase
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.kind    = KIND_BYTE;
    in_ch.rx_byte = '0;
    out_ch.ready  = 1'b0;
    err_count     = 0;
    items_sent    = 0;
    idle_on       = 1'b1;
    stall_left    = 0;
    parse_state      = ST_HUNT;
    frame_pos        = '0;
    frame_xor        = '0;
    latched_angle    = '0;
    latched_distance = '0;
    latched_seen     = 1'b0;
    age_count        = AGE_MAX;
    timeout_ticks    = TIMEOUT_RESET;
    for (int i = 0; i < PAYLOAD_LEN; i++) frame_bytes[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_and_hunt();
    test_timeout_max();
    test_frame_accept();
    test_frame_reject();
    test_random_phases();

    // Let the last readouts come out, then settle for the pipeline depth
    drain_results();
    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #(5_000_000);
    $display("FAIL");
    $finish;
  end

endmodule
